>>> hdl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg: shared types and constants for the stereo biquad filter
// Coefficient format, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package sbq_pkg;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEFAULT    = 24;
  localparam int COEF_FRAC_BITS_DEFAULT = 16;

  // Coefficients are signed Q2.16, fixed width
  localparam int COEF_BITS      = 18;
  localparam int CFG_INDEX_BITS = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_A2 = 3'd4;

  // Reset value of b0 is 1.0 in Q2.16
  localparam logic signed [COEF_BITS-1:0] COEF_B0_RESET = 18'sd65536;

  // The five coefficients shared by both channels
  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_t;

endpackage

>>> hdl/sbq_channel.sv
// ----------------------------------------------------------------------------
// sbq_channel: one direct form I biquad section
// Holds the two past inputs and outputs of one channel, forms the
// five-tap sum, shifts it down and saturates it to the sample width.
// ----------------------------------------------------------------------------
module sbq_channel #(
  parameter int SAMPLE_BITS    = sbq_pkg::SAMPLE_BITS_DEFAULT,
  parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  sbq_pkg::coef_t                coef,
  input  logic signed [SAMPLE_BITS-1:0] x,
  output logic signed [SAMPLE_BITS-1:0] y,
  output logic                          sat
);

  localparam int PROD_W = SAMPLE_BITS + sbq_pkg::COEF_BITS;
  localparam int ACC_W  = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] Y_MAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

  logic signed [SAMPLE_BITS-1:0] x1, x2, y1, y2;
  logic signed [PROD_W-1:0]      p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       shifted;

  // Form the five products in parallel
  assign p_b0 = PROD_W'(x)  * PROD_W'($signed(coef.b0));
  assign p_b1 = PROD_W'(x1) * PROD_W'($signed(coef.b1));
  assign p_b2 = PROD_W'(x2) * PROD_W'($signed(coef.b2));
  assign p_a1 = PROD_W'(y1) * PROD_W'($signed(coef.a1));
  assign p_a2 = PROD_W'(y2) * PROD_W'($signed(coef.a2));

  // Sum feed-forward taps, subtract feedback taps
  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2);

  // Drop fraction bits, rounding toward minus infinity
  assign shifted = acc >>> COEF_FRAC_BITS;

  // Clamp to the sample range
  always_comb begin
    if (shifted > Y_MAX) begin
      y   = Y_MAX[SAMPLE_BITS-1:0];
      sat = 1'b1;
    end else if (shifted < Y_MIN) begin
      y   = Y_MIN[SAMPLE_BITS-1:0];
      sat = 1'b1;
    end else begin
      y   = shifted[SAMPLE_BITS-1:0];
      sat = 1'b0;
    end
  end

  // Advance the history when the item moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (advance) begin
      x2 <= x1;
      x1 <= x;
      y2 <= y1;
      y1 <= y;
    end
  end

endmodule

>>> hdl/stereo_biquad_iir_filter.sv
// ----------------------------------------------------------------------------
// stereo_biquad_iir_filter: stereo second-order IIR section, direct form I
// Both channels run the same five coefficients; saturated SAMPLE_BITS results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one stereo pair and a
//   block_end mark per item. Output channel (out_valid / out_ready) carries
//   the filtered pair, a clipped flag and block_end_out per item.
//   Coefficients are written through cfg_we / cfg_index / cfg_data while
//   the filter is idle; writes to indexes past coef_a2 are ignored.
//   An accepted item passes the input register, then the output register,
//   which holds it while out_ready is low. Throughput is one item per
//   cycle while out_ready is high; products, sum and clamp sit between
//   the registers; history updates in the same cycle the result is loaded.
//   Reset clears the history of both channels, drops both registers and
//   sets b0 to 1.0 and the other coefficients to 0.
//   When the receiver stalls, the output register holds its item and the
//   input register takes one more item; after that in_ready drops until
//   out_ready returns.
// ----------------------------------------------------------------------------
module stereo_biquad_iir_filter #(
  parameter int SAMPLE_BITS    = sbq_pkg::SAMPLE_BITS_DEFAULT,
  parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [sbq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sbq_pkg::COEF_BITS-1:0]        cfg_data,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        sample_left,
  input  logic signed [SAMPLE_BITS-1:0]        sample_right,
  input  logic                                 block_end,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        filtered_left,
  output logic signed [SAMPLE_BITS-1:0]        filtered_right,
  output logic                                 clipped,
  output logic                                 block_end_out
);

  sbq_pkg::coef_t coef;

  logic                          stage_valid;
  logic signed [SAMPLE_BITS-1:0] stage_left;
  logic signed [SAMPLE_BITS-1:0] stage_right;
  logic                          stage_end;
  logic                          stage_advance;

  logic signed [SAMPLE_BITS-1:0] y_left, y_right;
  logic                          sat_left, sat_right;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= sbq_pkg::COEF_B0_RESET;
      coef.b1 <= '0;
      coef.b2 <= '0;
      coef.a1 <= '0;
      coef.a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbq_pkg::REG_B0: coef.b0 <= $signed(cfg_data);
        sbq_pkg::REG_B1: coef.b1 <= $signed(cfg_data);
        sbq_pkg::REG_B2: coef.b2 <= $signed(cfg_data);
        sbq_pkg::REG_A1: coef.a1 <= $signed(cfg_data);
        sbq_pkg::REG_A2: coef.a2 <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Move the staged item on when the output register is free or draining
  assign stage_advance = stage_valid && (!out_valid || out_ready);
  assign in_ready      = !stage_valid || stage_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (stage_advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_left  <= sample_left;
      stage_right <= sample_right;
      stage_end   <= block_end;
    end
  end

  // One section per channel
  sbq_channel #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_left (
    .clk     (clk),
    .rst     (rst),
    .advance (stage_advance),
    .coef    (coef),
    .x       (stage_left),
    .y       (y_left),
    .sat     (sat_left)
  );

  sbq_channel #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_right (
    .clk     (clk),
    .rst     (rst),
    .advance (stage_advance),
    .coef    (coef),
    .x       (stage_right),
    .y       (y_right),
    .sat     (sat_right)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      filtered_left  <= y_left;
      filtered_right <= y_right;
      clipped        <= sat_left || sat_right;
      block_end_out  <= stage_end;
    end
  end

  // Checks
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stage_valid && out_valid && !out_ready))
    else $error("in_ready low while a register is free");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    stage_advance |=> out_valid)
    else $error("advanced item did not reach the output register");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !stage_valid) |=> !out_valid)
    else $error("item repeated on the output");

  a_clip_at_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |->
      (filtered_left == S_MAX || filtered_left == S_MIN ||
       filtered_right == S_MAX || filtered_right == S_MIN))
    else $error("clipped set without a value at a bound");

endmodule
